FILE: design/aesxm_pkg.sv
// Package: shared types, constants and byte functions for the AES XCBC-MAC block.
`timescale 1ns / 1ps
`default_nettype none
package aesxm_pkg;

  localparam int unsigned BlockBytes = 16;
  localparam int unsigned HalfW      = 64;
  localparam int unsigned BlockW     = 128;
  localparam int unsigned CountW     = 5;
  localparam int unsigned AddrW      = 4;
  localparam int unsigned Rounds     = 10;

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [7:0] RconInit = 8'h01;

  // Register index, taken from paddr[3]
  localparam logic RegKeyHigh = 1'b0;
  localparam logic RegKeyLow  = 1'b1;

  typedef logic [7:0] byte_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KGO,
    ST_KRUN,
    ST_MGO,
    ST_MRUN,
    ST_HOLD
  } xm_state_t;

  localparam byte_t SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // GF(2^8) multiply by x
  function automatic byte_t xtime(input byte_t x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

endpackage
`default_nettype wire

FILE: design/aesxm_if.sv
// Interfaces: message word channel and MAC word channel.
`timescale 1ns / 1ps
`default_nettype none
interface aesxm_in_if import aesxm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [HalfW-1:0]  block_high;
  logic [HalfW-1:0]  block_low;
  logic [CountW-1:0] byte_count;
  logic              first_block;
  logic              last_block;
  modport source (output valid, block_high, block_low, byte_count, first_block, last_block,
                  input ready);
  modport sink (input valid, block_high, block_low, byte_count, first_block, last_block,
                output ready);
endinterface

interface aesxm_out_if import aesxm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [HalfW-1:0] mac_high;
  logic [HalfW-1:0] mac_low;
  modport source (output valid, mac_high, mac_low, input ready);
  modport sink (input valid, mac_high, mac_low, output ready);
endinterface
`default_nettype wire

FILE: design/aesxm_core.sv
// AES-128 encryption, byte-serial SubBytes and on-the-fly key schedule.
`timescale 1ns / 1ps
`default_nettype none
module aesxm_core import aesxm_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [BlockW-1:0] key_i,
  input  wire logic [BlockW-1:0] din_i,
  output logic                   busy,
  output logic                   done,
  output logic [BlockW-1:0]      dout
);

  byte_t      s_r [BlockBytes];
  byte_t      k_r [BlockBytes];
  logic [4:0] step_r;
  logic [3:0] round_r;
  byte_t      rc_r;
  logic       run_r;
  logic       done_r;

  logic [3:0] j;
  byte_t      ksrc, kmix, knew, sub_s;
  byte_t      t   [BlockBytes];
  byte_t      m   [BlockBytes];
  logic       last_round;
  logic       mix_step;

  assign j          = step_r[3:0];
  assign mix_step   = step_r[4];
  assign last_round = (round_r == 4'(Rounds));

  // next key byte from the rotating key register
  always_comb begin
    ksrc = (j == 4'd3) ? k_r[9] : k_r[13];
    if (j < 4'd4) kmix = SBOX[ksrc] ^ ((j == 4'd0) ? rc_r : 8'h00);
    else          kmix = k_r[12];
    knew  = k_r[0] ^ kmix;
    sub_s = SBOX[s_r[0]];
  end

  // ShiftRows and MixColumns; the last round skips MixColumns
  always_comb begin
    byte_t a0, a1, a2, a3, al;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        t[i + 4*c] = s_r[i + 4*((c + i) & 3)];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
      al = a0 ^ a1 ^ a2 ^ a3;
      if (last_round) begin
        m[4*c] = a0; m[4*c+1] = a1; m[4*c+2] = a2; m[4*c+3] = a3;
      end else begin
        m[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
        m[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
        m[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
        m[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
      end
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r   <= 1'b0;
      done_r  <= 1'b0;
      step_r  <= '0;
      round_r <= '0;
      rc_r    <= RconInit;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r   <= 1'b1;
        step_r  <= '0;
        round_r <= 4'd1;
        rc_r    <= RconInit;
      end else if (run_r) begin
        if (mix_step) begin
          step_r <= '0;
          if (last_round) begin
            run_r  <= 1'b0;
            done_r <= 1'b1;
          end else begin
            round_r <= round_r + 4'd1;
            rc_r    <= xtime(rc_r);
          end
        end else begin
          step_r <= step_r + 5'd1;
        end
      end
    end
  end

  // datapath shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      for (int i = 0; i < BlockBytes; i++) begin
        k_r[i] <= key_i[BlockW-1-8*i -: 8];
        s_r[i] <= din_i[BlockW-1-8*i -: 8] ^ key_i[BlockW-1-8*i -: 8];
      end
    end else if (run_r) begin
      if (mix_step) begin
        for (int i = 0; i < BlockBytes; i++) s_r[i] <= m[i] ^ k_r[i];
      end else begin
        for (int i = 0; i < BlockBytes-1; i++) begin
          s_r[i] <= s_r[i+1];
          k_r[i] <= k_r[i+1];
        end
        s_r[BlockBytes-1] <= sub_s;
        k_r[BlockBytes-1] <= knew;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < BlockBytes; i++) dout[BlockW-1-8*i -: 8] = s_r[i];
  end

  assign busy = run_r;
  assign done = done_r;

endmodule
`default_nettype wire

FILE: design/aes_xcbc_mac_top.sv
// AES-128 XCBC-style MAC over 16-byte words; last word whitened by subkey 3 if full, subkey 2 if padded.
// Sequence for a word without first_block: accept, then the AES unit loads the word and runs
//   ten rounds of 16 byte-serial S-box steps and one mix step each, then back to idle.
// A first word adds three subkey encryptions ahead of its own.
// Words are taken only in idle, after the single AES unit ends the last one and any MAC is registered.
// Reset (synchronous, rst_n low): key, subkeys and chaining value clear to zero; no MAC pending.
`timescale 1ns / 1ps
`default_nettype none
module aes_xcbc_mac_top import aesxm_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  aesxm_in_if.sink              in_ch,
  aesxm_out_if.source           out_ch,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [HalfW-1:0] pwdata,
  output logic [HalfW-1:0]      prdata,
  output logic                  pready
);

  xm_state_t         state_r, state_nxt;
  logic [1:0]        n_r;
  logic [HalfW-1:0]  key_hi_r, key_lo_r;
  logic [BlockW-1:0] sub_r [3];
  logic [BlockW-1:0] chain_r;
  logic [BlockW-1:0] blk_r;
  logic [CountW-1:0] cnt_r;
  logic              first_r, last_r;
  logic              out_valid_r;
  logic [BlockW-1:0] out_data_r;

  logic              in_acc, out_free, load_out;
  logic              core_start, core_busy, core_done;
  logic [BlockW-1:0] core_key, core_din, core_dout, msg_x;
  byte_t             cbyte;

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr[3] == RegKeyLow) ? key_lo_r : key_hi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_hi_r <= '0;
      key_lo_r <= '0;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[3] == RegKeyLow) key_lo_r <= pwdata;
      else                       key_hi_r <= pwdata;
    end
  end

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  // input word to encrypt: chain xor block, padded and whitened on the last word
  always_comb begin
    logic [CountW-1:0] cnt;
    logic              full;
    byte_t             b;
    cnt  = (cnt_r > CountW'(BlockBytes)) ? CountW'(BlockBytes) : cnt_r;
    full = (cnt == CountW'(BlockBytes));
    for (int i = 0; i < BlockBytes; i++) begin
      b = blk_r[BlockW-1-8*i -: 8];
      if (!last_r || full) msg_x[BlockW-1-8*i -: 8] = b;
      else if (CountW'(i) < cnt) msg_x[BlockW-1-8*i -: 8] = b;
      else if (CountW'(i) == cnt) msg_x[BlockW-1-8*i -: 8] = PadByte;
      else msg_x[BlockW-1-8*i -: 8] = 8'h00;
    end
    msg_x = msg_x ^ chain_r;
    if (last_r) msg_x = msg_x ^ (full ? sub_r[2] : sub_r[1]);
  end

  assign cbyte = 8'(n_r) + 8'd1;

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    core_start = 1'b0;
    core_key   = sub_r[0];
    core_din   = msg_x;
    load_out   = 1'b0;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = in_ch.first_block ? ST_KGO : ST_MGO;
      ST_KGO: begin
        core_start = 1'b1;
        core_key   = {key_hi_r, key_lo_r};
        core_din   = {BlockBytes{cbyte}};
        state_nxt  = ST_KRUN;
      end
      ST_KRUN: if (core_done) state_nxt = (n_r == 2'd2) ? ST_MGO : ST_KGO;
      ST_MGO: begin
        core_start = 1'b1;
        state_nxt  = ST_MRUN;
      end
      ST_MRUN: begin
        if (core_done) begin
          if (!last_r) state_nxt = ST_IDLE;
          else if (out_free) begin
            load_out  = 1'b1;
            state_nxt = ST_IDLE;
          end else state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r     <= '0;
      chain_r <= '0;
      for (int i = 0; i < 3; i++) sub_r[i] <= '0;
    end else begin
      if (state_r == ST_KRUN && core_done) begin
        sub_r[n_r] <= core_dout;
        if (n_r == 2'd2) begin
          n_r     <= '0;
          chain_r <= '0;
        end else n_r <= n_r + 2'd1;
      end
      if (state_r == ST_MRUN && core_done) chain_r <= last_r ? '0 : core_dout;
    end
  end

  // captured input word
  always_ff @(posedge clk) begin
    if (in_acc) begin
      blk_r   <= {in_ch.block_high, in_ch.block_low};
      cnt_r   <= in_ch.byte_count;
      first_r <= in_ch.first_block;
      last_r  <= in_ch.last_block;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (load_out) out_valid_r <= 1'b1;
    else if (out_ch.ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load_out) out_data_r <= core_dout;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.mac_high = out_data_r[BlockW-1:HalfW];
  assign out_ch.mac_low  = out_data_r[HalfW-1:0];

  aesxm_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .start (core_start),
    .key_i (core_key),
    .din_i (core_din),
    .busy  (core_busy),
    .done  (core_done),
    .dout  (core_dout)
  );

  // checks
  a_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    core_done |-> (state_r == ST_KRUN || state_r == ST_MRUN)) else $error("stray AES done");
  a_idle_core: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !core_busy) else $error("AES unit busy while idle");
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_MRUN || state_r == ST_HOLD))
    else $error("MAC word without final encryption");
  a_first_keys: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_KGO) |-> first_r) else $error("subkey pass without first word");

endmodule
`default_nettype wire
